[hw/rtl/ogq_pkg.sv]
// ----------------------------------------------------------------------------
// ogq_pkg: shared types and constants
// Widths, register codes, result codes and the item record that the front
// end hands to the back end of the occupancy grid point query block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ogq_pkg;

  localparam int unsigned MAP_CELLS_DEF  = 1048576;
  localparam int unsigned ADDR_W         = 20;
  localparam int unsigned VAL_W          = 8;
  localparam int unsigned COORD_W        = 32;
  localparam int unsigned SCALE_W        = 32;
  localparam int unsigned LEVEL_W        = 17;
  localparam int unsigned SIDE_W         = 11;
  localparam int unsigned CELL_IDX_W     = 25;  // holds any cell count up to 2^24
  localparam int unsigned PADDR_W        = 5;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned RESULT_LATENCY = 10;

  typedef enum logic [2:0] {
    REG_ORIGIN_X        = 3'd0,
    REG_ORIGIN_Y        = 3'd1,
    REG_CELLS_PER_METER = 3'd2,
    REG_OCCUPIED_LEVEL  = 3'd3,
    REG_FREE_LEVEL      = 3'd4,
    REG_INVERT_SHADING  = 3'd5,
    REG_MAP_WIDTH       = 3'd6,
    REG_MAP_HEIGHT      = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CLS_FREE     = 2'd0,
    CLS_OCCUPIED = 2'd1,
    CLS_UNKNOWN  = 2'd2
  } occ_class_t;

  typedef struct packed {
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [SCALE_W-1:0] cells_per_meter;
    logic [LEVEL_W-1:0] occupied_level;
    logic [LEVEL_W-1:0] free_level;
    logic               invert_shading;
    logic [SIDE_W-1:0]  map_width;
    logic [SIDE_W-1:0]  map_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    org_x:           32'd0,
    org_y:           32'd0,
    cells_per_meter: 32'd65536,
    occupied_level:  17'd42598,
    free_level:      17'd12780,
    invert_shading:  1'b0,
    map_width:       11'd1024,
    map_height:      11'd1024
  };

  // One item as the back end sees it: a store write or a cell read.
  typedef struct packed {
    logic                  is_load;
    logic                  in_map;
    logic [CELL_IDX_W-1:0] loc;
    logic [VAL_W-1:0]      value;
  } map_op_t;

endpackage

`default_nettype wire

[hw/rtl/ogq_regs.sv]
// ----------------------------------------------------------------------------
// ogq_regs: configuration registers
// APB-style register file holding origin, scale, thresholds and map size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogq_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ogq_pkg::PADDR_W-1:0]   paddr,
  input  logic [ogq_pkg::PDATA_W-1:0]   pwdata,
  output logic [ogq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output ogq_pkg::cfg_t                 cfg
);
  import ogq_pkg::*;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_X:        cfg.org_x           <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:        cfg.org_y           <= pwdata[COORD_W-1:0];
        REG_CELLS_PER_METER: cfg.cells_per_meter <= pwdata[SCALE_W-1:0];
        REG_OCCUPIED_LEVEL:  cfg.occupied_level  <= pwdata[LEVEL_W-1:0];
        REG_FREE_LEVEL:      cfg.free_level      <= pwdata[LEVEL_W-1:0];
        REG_INVERT_SHADING:  cfg.invert_shading  <= pwdata[0];
        REG_MAP_WIDTH:       cfg.map_width       <= pwdata[SIDE_W-1:0];
        REG_MAP_HEIGHT:      cfg.map_height      <= pwdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:        prdata = PDATA_W'(cfg.org_x);
      REG_ORIGIN_Y:        prdata = PDATA_W'(cfg.org_y);
      REG_CELLS_PER_METER: prdata = PDATA_W'(cfg.cells_per_meter);
      REG_OCCUPIED_LEVEL:  prdata = PDATA_W'(cfg.occupied_level);
      REG_FREE_LEVEL:      prdata = PDATA_W'(cfg.free_level);
      REG_INVERT_SHADING:  prdata = PDATA_W'(cfg.invert_shading);
      REG_MAP_WIDTH:       prdata = PDATA_W'(cfg.map_width);
      REG_MAP_HEIGHT:      prdata = PDATA_W'(cfg.map_height);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/ogq_front.sv]
// ----------------------------------------------------------------------------
// ogq_front: item intake and cell address pipeline
// Takes load and query items, turns query points into a column and a row,
// flags points outside the map and forms the linear cell index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogq_front #(
  parameter int unsigned MAP_CELLS = ogq_pkg::MAP_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ogq_pkg::cfg_t                 cfg,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [ogq_pkg::ADDR_W-1:0]    pixel_addr,
  input  logic [ogq_pkg::VAL_W-1:0]     pixel_value,
  input  logic [ogq_pkg::COORD_W-1:0]   world_x,
  input  logic [ogq_pkg::COORD_W-1:0]   world_y,
  input  logic                          q_full,
  output logic                          push,
  output ogq_pkg::map_op_t              push_op
);
  import ogq_pkg::*;

  localparam logic [CELL_IDX_W-1:0] CELLS_LIM = CELL_IDX_W'(MAP_CELLS);
  localparam logic [64:0]           HALF_Q32  = 65'h0_8000_0000;
  localparam logic [43:0]           HALF_ROW  = 44'h0_8000_0000;

  logic adv;

  // valid bits
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;
  // load payload and opcode carried alongside
  logic              s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q;
  logic [ADDR_W-1:0] s1_a, s2_a, s3_a, s4_a, s5_a, s6_a, s7_a;
  logic [VAL_W-1:0]  s1_d, s2_d, s3_d, s4_d, s5_d, s6_d, s7_d;

  logic [COORD_W-1:0] s1_wx, s1_wy;
  logic [COORD_W:0]   s2_dx, s2_dy;
  logic               s3_negx, s3_negy, s4_negx, s4_negy, s5_negx, s5_negy;
  logic [COORD_W-1:0] s3_magx, s3_magy;
  logic [63:0]        s4_mx, s4_my;
  logic [32:0]        s5_colr;
  logic               s5_ybig;
  logic [65:0]        s5_t;
  logic               s6_out;
  logic [SIDE_W-1:0]  s6_row, s6_col;
  logic               s7_out;
  logic [21:0]        s7_idx;

  logic [COORD_W:0]   abs_x, abs_y;
  logic [63:0]        prod_x, prod_y;
  logic [64:0]        sum_x;
  logic [SIDE_W-1:0]  h_m1;
  logic               col_out, row_out;
  logic [SIDE_W-1:0]  row;
  logic [43:0]        row_sum;
  logic [11:0]        row_r;
  logic [21:0]        row_base;
  logic [CELL_IDX_W-1:0] addr_ext, idx_ext;

  assign adv  = !q_full;
  assign busy = q_full;
  assign h_m1 = cfg.map_height - 11'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      {s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v} <= '0;
    end else if (adv) begin
      s1_v <= start;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_q <= (opcode == OP_QUERY);
      s1_a <= pixel_addr;
      s1_d <= pixel_value;
      {s2_q, s3_q, s4_q, s5_q, s6_q, s7_q} <= {s1_q, s2_q, s3_q, s4_q, s5_q, s6_q};
      {s2_a, s3_a, s4_a, s5_a, s6_a, s7_a} <= {s1_a, s2_a, s3_a, s4_a, s5_a, s6_a};
      {s2_d, s3_d, s4_d, s5_d, s6_d, s7_d} <= {s1_d, s2_d, s3_d, s4_d, s5_d, s6_d};
    end
  end

  // offsets from the origin, then magnitudes
  assign abs_x = s2_dx[COORD_W] ? (33'd0 - s2_dx) : s2_dx;
  assign abs_y = s2_dy[COORD_W] ? (33'd0 - s2_dy) : s2_dy;

  // scaled offsets in Q32
  assign prod_x = s3_magx * cfg.cells_per_meter;
  assign prod_y = s3_magy * cfg.cells_per_meter;

  assign sum_x = {1'b0, s4_mx} + HALF_Q32;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wx   <= world_x;
      s1_wy   <= world_y;
      s2_dx   <= {s1_wx[COORD_W-1], s1_wx} - {cfg.org_x[COORD_W-1], cfg.org_x};
      s2_dy   <= {s1_wy[COORD_W-1], s1_wy} - {cfg.org_y[COORD_W-1], cfg.org_y};
      s3_negx <= s2_dx[COORD_W];
      s3_negy <= s2_dy[COORD_W];
      s3_magx <= abs_x[COORD_W-1:0];
      s3_magy <= abs_y[COORD_W-1:0];
      s4_negx <= s3_negx;
      s4_negy <= s3_negy;
      s4_mx   <= prod_x;
      s4_my   <= prod_y;
      s5_negx <= s4_negx;
      s5_negy <= s4_negy;
      s5_colr <= sum_x[64:32];
      s5_ybig <= |s4_my[63:31];
      // (height-1) - scaled y, rounded later as one value
      s5_t    <= {23'd0, h_m1, 32'd0} - {2'b00, s4_my};
    end
  end

  assign col_out = (s5_negx && (s5_colr != 33'd0)) || (s5_colr >= 33'(cfg.map_width));
  assign row_sum = s5_t[43:0] + HALF_ROW;

  always_comb begin
    row_out = 1'b0;
    row     = '0;
    row_r   = row_sum[43:32];
    if (cfg.map_height == '0) begin
      row_out = 1'b1;
    end else if (s5_negy) begin
      // below the origin: any non-zero rounded offset leaves the map
      row_out = s5_ybig;
      row     = h_m1;
    end else if (!s5_t[65]) begin
      row_out = (row_r >= {1'b0, cfg.map_height});
      row     = row_r[SIDE_W-1:0];
    end else begin
      // above the top row: inside only while the overshoot rounds to zero
      row_out = !(&s5_t[65:31]) || (s5_t[30:0] == '0);
      row     = '0;
    end
  end

  assign row_base = s6_row * cfg.map_width;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_out <= col_out || row_out;
      s6_row <= row;
      s6_col <= s5_colr[SIDE_W-1:0];
      s7_out <= s6_out;
      s7_idx <= row_base + 22'(s6_col);
    end
  end

  assign addr_ext = CELL_IDX_W'(s7_a);
  assign idx_ext  = CELL_IDX_W'(s7_idx);

  assign push = s7_v && adv;

  always_comb begin
    push_op.is_load = !s7_q;
    push_op.value   = s7_d;
    if (s7_q) begin
      push_op.loc    = idx_ext;
      push_op.in_map = !s7_out && (idx_ext < CELLS_LIM);
    end else begin
      push_op.loc    = addr_ext;
      push_op.in_map = (addr_ext < CELLS_LIM);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ogq_queue.sv]
// ----------------------------------------------------------------------------
// ogq_queue: front-to-back item queue
// Small FIFO between address pipeline and map store; the head is handed
// to the back end in every cycle that the queue is not empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogq_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ogq_pkg::map_op_t  push_op,
  output logic              full,
  output logic              head_valid,
  output ogq_pkg::map_op_t  head_op
);
  import ogq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  map_op_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign pop        = (count != '0);
  assign head_valid = pop;
  assign head_op    = slots[rd_ptr];
  assign full       = (count == (PTR_W + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ogq_back.sv]
// ----------------------------------------------------------------------------
// ogq_back: map store and cell classifier
// Writes loaded pixels, reads queried cells and grades each cell as free,
// occupied or unknown against the two thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogq_back #(
  parameter int unsigned MAP_CELLS = ogq_pkg::MAP_CELLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ogq_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  ogq_pkg::map_op_t  head_op,
  output logic              done,
  output logic [1:0]        occupancy_class
);
  import ogq_pkg::*;

  localparam int unsigned AW = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;

  logic [VAL_W-1:0] mem [MAP_CELLS];
  logic [AW-1:0]    cell_addr;
  logic [VAL_W-1:0] rd_data;
  logic             b_v, b_out;
  logic [VAL_W-1:0] dark;
  logic [24:0]      lhs, occ_th, free_th;
  occ_class_t       cls, cls_q;

  assign cell_addr = head_op.loc[AW-1:0];

  always_ff @(posedge clk) begin
    if (head_valid && head_op.is_load && head_op.in_map) begin
      mem[cell_addr] <= head_op.value;
    end
    rd_data <= mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v  <= 1'b0;
      done <= 1'b0;
    end else begin
      b_v  <= head_valid && !head_op.is_load;
      done <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    b_out <= !head_op.in_map;
    cls_q <= cls;
  end

  // exact compare: darkness * 65536 against level * 255
  assign dark    = cfg.invert_shading ? rd_data : (8'd255 - rd_data);
  assign lhs     = {1'b0, dark, 16'd0};
  assign occ_th  = {cfg.occupied_level, 8'd0} - {8'd0, cfg.occupied_level};
  assign free_th = {cfg.free_level, 8'd0} - {8'd0, cfg.free_level};

  always_comb begin
    if (b_out) begin
      cls = CLS_OCCUPIED;
    end else if (lhs >= occ_th) begin
      cls = CLS_OCCUPIED;
    end else if (lhs <= free_th) begin
      cls = CLS_FREE;
    end else begin
      cls = CLS_UNKNOWN;
    end
  end

  assign occupancy_class = cls_q;

endmodule

`default_nettype wire

[hw/rtl/occupancy_grid_point_query_top.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_point_query_top: occupancy grid point query
// Grayscale map store filled by load items; query items return the class of
// the cell under a world point.
//
//   channel   handshake                  payload
//   item in   start / busy               opcode, pixel_addr, pixel_value,
//                                        world_x, world_y
//   result    done (one-cycle strobe)    occupancy_class
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per clock while busy is low. A query's result strobes once the query
// has passed seven address stages (one 32x32 multiply per axis), the queue, the
// store read and the output register. Loads give no result.
// busy is high only while the queue is full; the back end drains one entry
// per cycle and the receiver cannot stall, so it does not rise in practice.
// Reset is synchronous: clears pipeline, queue and registers to defaults;
// the map store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_point_query_top #(
  parameter int unsigned MAP_CELLS = ogq_pkg::MAP_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [ogq_pkg::ADDR_W-1:0]    pixel_addr,
  input  logic [ogq_pkg::VAL_W-1:0]     pixel_value,
  input  logic [ogq_pkg::COORD_W-1:0]   world_x,
  input  logic [ogq_pkg::COORD_W-1:0]   world_y,
  output logic                          done,
  output logic [1:0]                    occupancy_class,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ogq_pkg::PADDR_W-1:0]   paddr,
  input  logic [ogq_pkg::PDATA_W-1:0]   pwdata,
  output logic [ogq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ogq_pkg::*;

  cfg_t    cfg;
  logic    q_full, push, head_valid;
  map_op_t push_op, head_op;

  ogq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ogq_front #(
    .MAP_CELLS (MAP_CELLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .pixel_addr  (pixel_addr),
    .pixel_value (pixel_value),
    .world_x     (world_x),
    .world_y     (world_y),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op)
  );

  ogq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  ogq_back #(
    .MAP_CELLS (MAP_CELLS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head_valid      (head_valid),
    .head_op         (head_op),
    .done            (done),
    .occupancy_class (occupancy_class)
  );

endmodule

`default_nettype wire

[hw/rtl/ogq_checker.sv]
// ----------------------------------------------------------------------------
// ogq_checker: port-level checks
// Result timing against accepted items and register readback.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogq_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          opcode,
  input  logic                          done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ogq_pkg::PADDR_W-1:0]   paddr,
  input  logic [ogq_pkg::PDATA_W-1:0]   pwdata,
  input  logic [ogq_pkg::PDATA_W-1:0]   prdata
);
  import ogq_pkg::*;

  localparam logic [PADDR_W-1:0] INV_ADDR = {REG_INVERT_SHADING, 2'b00};

  logic query_in, load_in, inv_wr;

  assign query_in = start && !busy && (opcode == OP_QUERY);
  assign load_in  = start && !busy && (opcode == OP_LOAD);
  assign inv_wr   = psel && penable && pwrite && (paddr == INV_ADDR);

  a_query_answered: assert property (@(posedge clk) disable iff (rst)
    query_in |-> ##RESULT_LATENCY done)
    else $error("query item without result");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    load_in |-> ##RESULT_LATENCY !done)
    else $error("load item produced a result");

  a_result_traced: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(query_in, RESULT_LATENCY))
    else $error("result without matching query item");

  a_invert_readback: assert property (@(posedge clk) disable iff (rst)
    inv_wr |=> ((paddr != INV_ADDR) || (prdata == PDATA_W'($past(pwdata[0])))))
    else $error("invert_shading readback mismatch");

endmodule

bind occupancy_grid_point_query_top ogq_checker u_ogq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .opcode  (opcode),
  .done    (done),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata)
);

`default_nettype wire

[sim/occupancy_grid_point_query_top_tb.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_point_query_top_tb: self-checking bench for the grid query
// Fills the map store with load items and streams world-point queries through
// the block in phases, each under its own map geometry, scale, origin and
// thresholds (written over APB while the block is idle). A local predictor
// tracks the store and the registers and works out the class of every query
// at acceptance; the monitor checks each done strobe against the oldest one.
// Queries that land inside the map are preceded by a load of their cell when
// that cell has not been written yet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module occupancy_grid_point_query_top_tb;
  import ogq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [63:0] HALF_Q32 = 64'h8000_0000;

  typedef struct {
    opcode_t     op;
    logic [19:0] addr;
    logic [7:0]  value;
    logic [31:0] wx;
    logic [31:0] wy;
    bit          hold;  // wait for all outstanding results before this item
  } grid_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                opcode = OP_LOAD;
  logic [ADDR_W-1:0]   pixel_addr = '0;
  logic [VAL_W-1:0]    pixel_value = '0;
  logic [COORD_W-1:0]  world_x = '0;
  logic [COORD_W-1:0]  world_y = '0;
  logic                done;
  logic [1:0]          occupancy_class;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  occupancy_grid_point_query_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .pixel_addr      (pixel_addr),
    .pixel_value     (pixel_value),
    .world_x         (world_x),
    .world_y         (world_y),
    .done            (done),
    .occupancy_class (occupancy_class),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  // predictor state
  cfg_t        grid_cfg = CFG_RESET;
  logic [7:0]  cell_value [int unsigned];   // store contents as accepted
  bit          cell_loaded [int unsigned];  // cells with a load already queued
  occ_class_t  class_due [$];
  grid_item_t  item_backlog [$];
  grid_item_t  on_port;
  bit          hold_next = 1'b0;
  bit          sender_steady = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Cell under a world point; 0 when the point is off the map or past the store.
  function automatic bit locate_cell(logic [31:0] wx, logic [31:0] wy,
                                     output int unsigned idx);
    longint      d;
    logic [63:0] m, col, row, h1, flat;
    idx = 0;
    d = longint'($signed(wx)) - longint'($signed(grid_cfg.org_x));
    m = (d < 0) ? 64'(-d) : 64'(d);
    m = m * 64'(grid_cfg.cells_per_meter);
    col = (m + HALF_Q32) >> 32;
    if ((d < 0 && col != 0) || col >= 64'(grid_cfg.map_width) || grid_cfg.map_height == 0)
      return 1'b0;
    d = longint'($signed(wy)) - longint'($signed(grid_cfg.org_y));
    m = (d < 0) ? 64'(-d) : 64'(d);
    m = m * 64'(grid_cfg.cells_per_meter);
    h1 = (64'(grid_cfg.map_height) - 64'd1) << 32;
    // row is rounded from (height-1 - y_scaled) taken as one value
    if (d < 0) begin
      row = 64'(grid_cfg.map_height) - 64'd1 + ((m + HALF_Q32) >> 32);
    end else if (m <= h1) begin
      row = (h1 - m + HALF_Q32) >> 32;
    end else if (((m - h1 + HALF_Q32) >> 32) != 0) begin
      return 1'b0;
    end else begin
      row = 64'd0;
    end
    if (row >= 64'(grid_cfg.map_height))
      return 1'b0;
    flat = row * 64'(grid_cfg.map_width) + col;
    if (flat >= 64'(MAP_CELLS_DEF))
      return 1'b0;
    idx = flat[31:0];
    return 1'b1;
  endfunction

  function automatic occ_class_t classify_shade(logic [7:0] v);
    logic [31:0] dark_scaled;
    dark_scaled = (grid_cfg.invert_shading ? 32'(v) : 32'(8'd255 - v)) << 16;
    if (dark_scaled >= 32'(grid_cfg.occupied_level) * 32'd255)
      return CLS_OCCUPIED;
    if (dark_scaled <= 32'(grid_cfg.free_level) * 32'd255)
      return CLS_FREE;
    return CLS_UNKNOWN;
  endfunction

  function automatic occ_class_t predicted_class(logic [31:0] wx, logic [31:0] wy);
    int unsigned idx;
    if (!locate_cell(wx, wy, idx))
      return CLS_OCCUPIED;
    return classify_shade(cell_value[idx]);
  endfunction

  task automatic push_item(grid_item_t it);
    it.hold = hold_next;
    hold_next = 1'b0;
    item_backlog.insert(item_backlog.size(), it);
  endtask

  task automatic add_load(logic [19:0] addr, logic [7:0] value);
    grid_item_t it;
    it.op = OP_LOAD;
    it.addr = addr;
    it.value = value;
    it.wx = $urandom;
    it.wy = $urandom;
    cell_loaded[addr] = 1'b1;
    push_item(it);
  endtask

  task automatic add_query(logic [31:0] wx, logic [31:0] wy);
    grid_item_t  it;
    int unsigned idx;
    if (locate_cell(wx, wy, idx) && !cell_loaded.exists(idx))
      add_load(idx[19:0], 8'($urandom_range(255, 0)));
    it.op = OP_QUERY;
    it.addr = 20'($urandom);
    it.value = 8'($urandom);
    it.wx = wx;
    it.wy = wy;
    push_item(it);
  endtask

  // Query a point around the map, at the current scale; sometimes on a half cell.
  task automatic add_near_query();
    logic [63:0] span, lim_x, lim_y;
    longint      step, offx, offy;
    span = (grid_cfg.cells_per_meter == 0) ? 64'd65536
                                            : 64'h1_0000_0000 / 64'(grid_cfg.cells_per_meter);
    if (span > 64'h0100_0000)
      span = 64'h0100_0000;
    step = longint'(span);
    lim_x = (64'(grid_cfg.map_width) + 64'd4) * span;
    lim_y = (64'(grid_cfg.map_height) + 64'd4) * span;
    if (lim_x > 64'hFFFF_FFFF) lim_x = 64'hFFFF_FFFF;
    if (lim_y > 64'hFFFF_FFFF) lim_y = 64'hFFFF_FFFF;
    offx = longint'(64'($urandom_range(32'(lim_x), 0))) - 2 * step;
    offy = longint'(64'($urandom_range(32'(lim_y), 0))) - 2 * step;
    if ($urandom_range(3, 0) == 0)
      offx = (offx / step) * step + step / 2;
    if ($urandom_range(3, 0) == 0)
      offy = (offy / step) * step + step / 2;
    add_query(grid_cfg.org_x + offx[31:0], grid_cfg.org_y + offy[31:0]);
  endtask

  task automatic run_random(int unsigned count);
    logic [63:0] ncell;
    ncell = 64'(grid_cfg.map_width) * 64'(grid_cfg.map_height);
    if (ncell == 0 || ncell > 64'(MAP_CELLS_DEF))
      ncell = 64'(MAP_CELLS_DEF);
    repeat (count) begin
      case ($urandom_range(19, 0))
        11, 12:         add_query($urandom, $urandom);
        13, 14, 15, 16: add_load(20'($urandom_range(32'(ncell - 1), 0)), 8'($urandom));
        17:             add_load(20'($urandom), 8'($urandom));
        18: begin
          hold_next = 1'b1;
          add_near_query();
        end
        default:        add_near_query();
      endcase
    end
  endtask

  task automatic wait_idle();
    while (item_backlog.size() != 0 || start || class_due.size() != 0)
      @(posedge clk);
    // trailing loads give no strobe; let them clear the pipeline
    repeat (RESULT_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(r) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_ORIGIN_X:        grid_cfg.org_x = v;
      REG_ORIGIN_Y:        grid_cfg.org_y = v;
      REG_CELLS_PER_METER: grid_cfg.cells_per_meter = v;
      REG_OCCUPIED_LEVEL:  grid_cfg.occupied_level = v[LEVEL_W-1:0];
      REG_FREE_LEVEL:      grid_cfg.free_level = v[LEVEL_W-1:0];
      REG_INVERT_SHADING:  grid_cfg.invert_shading = v[0];
      REG_MAP_WIDTH:       grid_cfg.map_width = v[SIDE_W-1:0];
      REG_MAP_HEIGHT:      grid_cfg.map_height = v[SIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_map(logic [31:0] ox, logic [31:0] oy, logic [31:0] cpm,
                         logic [16:0] occ, logic [16:0] free_lvl, logic inv,
                         logic [10:0] w, logic [10:0] h);
    wait_idle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_CELLS_PER_METER, cpm);
    write_reg(REG_OCCUPIED_LEVEL, 32'(occ));
    write_reg(REG_FREE_LEVEL, 32'(free_lvl));
    write_reg(REG_INVERT_SHADING, 32'(inv));
    write_reg(REG_MAP_WIDTH, 32'(w));
    write_reg(REG_MAP_HEIGHT, 32'(h));
  endtask

  // item driver: bursts with random gaps, predictor updated on acceptance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (start && !busy) begin
        if (on_port.op == OP_LOAD)
          cell_value[32'(on_port.addr)] = on_port.value;
        else
          class_due.insert(class_due.size(), predicted_class(on_port.wx, on_port.wy));
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (item_backlog.size() != 0 &&
                     !(item_backlog[0].hold && class_due.size() != 0)) begin
          on_port = item_backlog.pop_front();
          opcode <= on_port.op;
          pixel_addr <= on_port.addr;
          pixel_value <= on_port.value;
          world_x <= on_port.wx;
          world_y <= on_port.wy;
          start <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= sender_steady ? 0 : $urandom_range(8, 0);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    occ_class_t want;
    if (!rst && done) begin
      if (class_due.size() == 0) begin
        $error("occupancy_class: no result expected, got %0d", occupancy_class);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = class_due.pop_front();
        if (occupancy_class !== want) begin
          $error("occupancy_class: expected %0d, got %0d", want, occupancy_class);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("occupancy_grid_point_query_top_tb: errors");
      $finish;
    end
  end

  initial begin
    // directed items on the reset map: 1024 x 1024, 1 cell per metre, origin 0
    add_load(20'd0, 8'd0);
    add_load(20'hFFFFF, 8'd255);
    add_load(20'd1, 8'd89);   // darkness 166: just occupied
    add_load(20'd2, 8'd90);   // darkness 165: unknown
    add_load(20'd3, 8'd205);  // darkness 50: unknown
    add_load(20'd4, 8'd206);  // darkness 49: just free
    add_query(32'h0000_0000, 32'h03FF_0000);
    add_query(32'h03FF_0000, 32'h0000_0000);
    hold_next = 1'b1;
    for (int c = 1; c <= 4; c++)
      add_query(32'(c) << 16, 32'h03FF_0000);
    add_query(-32'sh7FFF, 32'h03FF_0000);           // rounds back to column 0
    add_query(-32'sh8000, 32'h03FF_0000);           // half a cell left: outside
    add_query(32'h03FF_7FFF, 32'h0000_0000);
    add_query(32'h03FF_8000, 32'h0000_0000);        // column rounds to width
    add_query(32'h0000_0000, 32'h03FF_7FFF);
    add_query(32'h0000_0000, 32'h03FF_8000);        // above the top row
    add_query(32'h0000_0000, -32'sh7FFF);
    add_query(32'h0000_0000, -32'sh8000);           // below the bottom row
    add_query(32'h8000_0000, 32'h7FFF_FFFF);
    add_query(32'h7FFF_FFFF, 32'h8000_0000);
    run_random(150);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // quarter-metre cells, thresholds at the exact ends, bright means occupied
    set_map(-32'sd344064, 32'sd229376, 32'd262144, 17'd65536, 17'd0, 1'b1,
            11'd40, 11'd30);
    sender_steady = 1'b1;
    run_random(150);
    // extreme origin and scale, single cell, occupied and free levels at their limits
    set_map(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd0, 17'h1FFFF, 1'b0,
            11'd1, 11'd1);
    sender_steady = 1'b0;
    run_random(80);
    // zero scale: every point lands on column 0 of the bottom row
    set_map(32'd12345, -32'sd98765, 32'd0, 17'h1FFFF, 17'h1FFFF, 1'b1, 11'd5, 11'd7);
    run_random(80);
    // zero width
    set_map(32'd0, 32'd0, 32'd65536, 17'd42598, 17'd12780, 1'b0, 11'd0, 11'd9);
    run_random(40);
    // widest map: far rows fall past the end of the store
    set_map(-32'sh0001_0000, 32'h0001_0000, 32'd32768, 17'd30000, 17'd20000, 1'b0,
            11'd2047, 11'd2047);
    run_random(150);
    // zero height
    set_map(32'h0010_0000, 32'h0020_0000, 32'd65536, 17'd42598, 17'd12780, 1'b1,
            11'd12, 11'd0);
    run_random(40);
    // smallest non-zero scale
    set_map(32'hFFFF_0000, 32'h0000_8000, 32'd1, 17'd40000, 17'd10000, 1'b0, 11'd3, 11'd3);
    run_random(40);
    for (int p = 0; p < 3; p++) begin
      set_map($urandom, $urandom, $urandom_range(32'h0010_0000, 32'h0000_4000),
              17'($urandom_range(70000, 0)), 17'($urandom_range(70000, 0)),
              1'($urandom_range(1, 0)),
              11'($urandom_range(64, 1)), 11'($urandom_range(64, 1)));
      sender_steady = (p == 1);
      run_random(150);
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("occupancy_grid_point_query_top_tb: clean");
    else
      $display("occupancy_grid_point_query_top_tb: errors");
    $finish;
  end

endmodule
